// ----- rtl/mobt_pkg.sv -----
// Shared constants, types and the sigmoid table builder for the perceptron trainer.
package mobt_pkg;

    localparam int MAX_LAYERS  = 4;
    localparam int MAX_NODES   = 8;
    localparam int INPUT_COUNT = 2;
    localparam int FRAC_BITS   = 12;
    localparam int SIG_DEPTH   = 1024;

    localparam int ONE     = 1 << FRAC_BITS;
    localparam int LAYER_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int NODE_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W   = $clog2(MAX_NODES + 1);
    localparam int LCNT_W  = $clog2(MAX_LAYERS + 1);
    localparam int LANE_AW = LAYER_W + NODE_W;
    localparam int IN_CNT  = (INPUT_COUNT < MAX_NODES) ? INPUT_COUNT : MAX_NODES;

    localparam int WGT_W   = 24;
    localparam int FEAT_W  = 16;
    localparam int X_W     = FEAT_W + 1;
    localparam int Y_W     = FRAC_BITS + 1;
    localparam int RATE_W  = 13;
    localparam int ERR_W   = 24;
    localparam int ACC_W   = WGT_W + X_W + NODE_W;
    localparam int NET_W   = ACC_W - FRAC_BITS + 1;
    localparam int G_W     = WGT_W + Y_W + 1 - FRAC_BITS;
    localparam int STEP_W  = RATE_W + 1 + G_W - FRAC_BITS;
    localparam int BPROD_W = WGT_W + G_W;
    localparam int SUM_W   = BPROD_W + NODE_W;
    localparam int UPROD_W = STEP_W + X_W;
    localparam int SIG_IW  = $clog2(SIG_DEPTH);
    localparam int SIG_STEP = ((16 * ONE) / SIG_DEPTH > 0) ? (16 * ONE) / SIG_DEPTH : 1;
    localparam int DIV_BITS = 48;

    localparam longint WGT_MAX = (longint'(1) << (WGT_W - 1)) - 1;
    localparam longint WGT_MIN = -(longint'(1) << (WGT_W - 1));

    typedef enum logic [1:0] {
        ACT_LOAD_W = 2'd0,
        ACT_LOAD_B = 2'd1,
        ACT_TRAIN  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        REG_LAYER_COUNT   = 2'd0,
        REG_HIDDEN_NODES  = 2'd1,
        REG_LEARNING_RATE = 2'd2,
        REG_ERROR_LIMIT   = 2'd3
    } reg_index_t;

    typedef enum logic [3:0] {
        LOP_IDLE,
        LOP_WLOAD,
        LOP_BLOAD,
        LOP_CLEAR,
        LOP_READ,
        LOP_MAC,
        LOP_NET,
        LOP_PRIME,
        LOP_GRAD,
        LOP_BPROD,
        LOP_STEP,
        LOP_UMUL,
        LOP_WRITE,
        LOP_BIAS
    } lane_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_F_CLR,
        ST_F_RD,
        ST_F_MAC,
        ST_F_NET,
        ST_S_IDX,
        ST_S_Y,
        ST_B_OUT,
        ST_B_GOUT,
        ST_B_RD,
        ST_B_PROD,
        ST_B_SUM1,
        ST_B_SUM2,
        ST_B_GRAD,
        ST_U_STEP,
        ST_U_RD,
        ST_U_MUL,
        ST_U_WR,
        ST_U_BIAS,
        ST_E_OUT
    } state_t;

    typedef struct packed {
        lane_op_t                  op;
        logic [NODE_W-1:0]         sel;
        logic [LAYER_W-1:0]        layer;
        logic [NODE_W-1:0]         src;
        logic [CNT_W-1:0]          nodes;
        logic signed [WGT_W-1:0]   value;
        logic signed [X_W-1:0]     x;
        logic [Y_W-1:0]            y;
        logic [RATE_W-1:0]         rate;
    } lane_ctrl_t;

    typedef logic signed [BPROD_W-1:0] bprod_t;
    typedef logic signed [NET_W-1:0]   net_t;
    typedef logic [Y_W-1:0]            sig_rom_t [SIG_DEPTH];

    function automatic logic signed [WGT_W-1:0] sat_wgt(input logic signed [63:0] v);
        logic signed [WGT_W-1:0] r;
        if (v > WGT_MAX) begin
            r = WGT_W'(WGT_MAX);
        end
        else if (v < WGT_MIN) begin
            r = WGT_W'(WGT_MIN);
        end
        else begin
            r = WGT_W'(v);
        end
        return r;
    endfunction

    // Shift-and-subtract quotient of two non-negative values, used only while building the table.
    function automatic longint udiv(input longint num, input longint den);
        longint quo;
        longint rem;
        quo = 0;
        rem = 0;
        for (int b = DIV_BITS - 1; b >= 0; b--) begin
            rem = (rem << 1) | ((num >> b) & longint'(1));
            quo = quo << 1;
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | longint'(1);
            end
        end
        return quo;
    endfunction

    function automatic sig_rom_t build_sig_rom();
        sig_rom_t rom;
        longint   step;
        longint   z;
        longint   a;
        longint   n;
        longint   f;
        longint   term;
        longint   sum;
        longint   e;
        longint   d;
        longint   p;
        step = longint'(SIG_STEP);
        for (int i = 0; i < SIG_DEPTH; i++) begin
            z = -8 * longint'(ONE) + longint'(i) * step;
            a = (z < 0) ? -z : z;
            n = a >>> FRAC_BITS;
            f = a & longint'(ONE - 1);
            term = longint'(1) << 30;
            sum = term;
            for (int k = 1; k <= 16; k++) begin
                term = udiv(term * f, longint'(k) * longint'(ONE));
                if ((k & 1) == 1) begin
                    sum = sum - term;
                end
                else begin
                    sum = sum + term;
                end
            end
            e = sum;
            for (longint r = 0; r < n; r++) begin
                e = (e * 395007542) >>> 30;
            end
            d = (longint'(1) << 30) + e;
            p = udiv((longint'(ONE) << 30) + (d >> 1), d);
            rom[i] = Y_W'((z >= 0) ? p : (longint'(ONE) - p));
        end
        return rom;
    endfunction

endpackage

// ----- rtl/mlp_online_backprop_trainer_top.sv -----
// Top level: controller, configuration registers, node lanes, merge tree and result register.
// A load transaction is applied while idle. A train transaction runs the forward pass over all
// layers, the backward pass that derives the deltas of each lower layer, and the weight and bias
// update per layer, stepping through the lane weight memories one source at a time.
// One item is worked at a time.
// Reset (asynchronous, active low) clears control state and the error sum, loads register defaults.
module mlp_online_backprop_trainer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // feature_a, feature_b, target, layer_sel, node_sel, source_sel, load_value
    input  logic [79:0] s_tdata,
    // action
    input  logic [1:0]  s_tuser,
    // epoch_end
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // network_output, epoch_error, converged
    output logic [39:0] m_tdata,
    // error_valid
    output logic        m_tuser,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [12:0] wr_data
);

    localparam int LW = mobt_pkg::LAYER_W;
    localparam int NW = mobt_pkg::NODE_W;
    localparam int CW = mobt_pkg::CNT_W;

    logic [2:0]                        layer_count_reg;
    logic [3:0]                        hidden_nodes_reg;
    logic [mobt_pkg::RATE_W-1:0]       learning_rate_reg;
    logic [12:0]                       error_limit_reg;

    mobt_pkg::state_t                  state_reg, state_next;
    logic [LW-1:0]                     layer_reg, layer_next;
    logic [NW-1:0]                     k_reg, k_next;
    logic                              m_tvalid_reg, m_tvalid_next;
    logic [mobt_pkg::ERR_W-1:0]        err_acc_reg, err_acc_next;

    logic signed [mobt_pkg::X_W-1:0]   inp_reg [mobt_pkg::MAX_LAYERS][mobt_pkg::MAX_NODES];
    logic [12:0]                       target_reg;
    logic                              epoch_end_reg;
    logic [mobt_pkg::Y_W-1:0]          yout_reg;
    logic signed [mobt_pkg::WGT_W-1:0] delta_reg;
    logic [12:0]                       out_y_reg;
    logic [mobt_pkg::ERR_W-1:0]        out_err_reg;
    logic                              out_valid_reg;
    logic                              out_conv_reg;

    logic                              accept;
    logic [mobt_pkg::LCNT_W-1:0]       l_eff;
    logic [CW-1:0]                     h_eff;
    logic [LW-1:0]                     last_layer;
    logic [CW-1:0]                     cur_nodes;
    logic [CW-1:0]                     cur_srcs;
    logic                              k_end_nodes;
    logic                              k_end_srcs;
    logic signed [mobt_pkg::X_W-1:0]   x_cur;
    mobt_pkg::lane_ctrl_t              ctrl;
    mobt_pkg::net_t                    lane_net [mobt_pkg::MAX_NODES];
    mobt_pkg::bprod_t                  lane_bprod [mobt_pkg::MAX_NODES];
    logic signed [mobt_pkg::SUM_W-1:0] total;
    logic [mobt_pkg::Y_W-1:0]          y_sig;
    logic signed [mobt_pkg::WGT_W-1:0] lower_delta;
    logic signed [13:0]                err_diff;
    logic [27:0]                       err_sq;
    logic [mobt_pkg::ERR_W:0]          err_sum;
    logic [mobt_pkg::ERR_W-1:0]        err_sat;
    logic                              out_free;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = state_reg == mobt_pkg::ST_IDLE;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        if (layer_count_reg == '0) begin
            l_eff = mobt_pkg::LCNT_W'(1);
        end
        else if (mobt_pkg::LCNT_W'(layer_count_reg) > mobt_pkg::LCNT_W'(mobt_pkg::MAX_LAYERS)) begin
            l_eff = mobt_pkg::LCNT_W'(mobt_pkg::MAX_LAYERS);
        end
        else begin
            l_eff = mobt_pkg::LCNT_W'(layer_count_reg);
        end
        if (hidden_nodes_reg == '0) begin
            h_eff = CW'(1);
        end
        else if (CW'(hidden_nodes_reg) > CW'(mobt_pkg::MAX_NODES)) begin
            h_eff = CW'(mobt_pkg::MAX_NODES);
        end
        else begin
            h_eff = CW'(hidden_nodes_reg);
        end
        last_layer  = LW'(l_eff - 1'b1);
        cur_nodes   = (layer_reg == last_layer) ? CW'(1) : h_eff;
        cur_srcs    = (layer_reg == '0) ? CW'(mobt_pkg::IN_CNT) : h_eff;
        k_end_nodes = {1'b0, k_reg} == cur_nodes - 1'b1;
        k_end_srcs  = {1'b0, k_reg} == cur_srcs - 1'b1;
        x_cur       = inp_reg[layer_reg][k_reg];
        lower_delta = mobt_pkg::sat_wgt(64'(total >>> mobt_pkg::FRAC_BITS));
        err_diff    = $signed({1'b0, target_reg}) - $signed({1'b0, yout_reg});
        err_sq      = 28'(err_diff * err_diff);
        err_sum     = {1'b0, err_acc_reg} + (mobt_pkg::ERR_W+1)'(err_sq >> mobt_pkg::FRAC_BITS);
        err_sat     = err_sum[mobt_pkg::ERR_W] ? '1 : err_sum[mobt_pkg::ERR_W-1:0];
    end

    always_comb
    begin
        state_next    = state_reg;
        layer_next    = layer_reg;
        k_next        = k_reg;
        m_tvalid_next = m_tvalid_reg;
        err_acc_next  = err_acc_reg;
        ctrl          = '0;
        ctrl.op       = mobt_pkg::LOP_IDLE;
        ctrl.sel      = k_reg;
        ctrl.layer    = layer_reg;
        ctrl.src      = k_reg;
        ctrl.nodes    = cur_nodes;
        ctrl.value    = delta_reg;
        ctrl.x        = x_cur;
        ctrl.y        = y_sig;
        ctrl.rate     = learning_rate_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            mobt_pkg::ST_IDLE:
            begin
                if (accept) begin
                    ctrl.sel   = s_tdata[49:47];
                    ctrl.layer = s_tdata[46:45];
                    ctrl.src   = s_tdata[52:50];
                    ctrl.value = s_tdata[76:53];
                    case (s_tuser)
                        mobt_pkg::ACT_LOAD_W:
                        begin
                            ctrl.op = mobt_pkg::LOP_WLOAD;
                        end
                        mobt_pkg::ACT_LOAD_B:
                        begin
                            ctrl.op = mobt_pkg::LOP_BLOAD;
                        end
                        mobt_pkg::ACT_TRAIN:
                        begin
                            layer_next = '0;
                            k_next     = '0;
                            state_next = mobt_pkg::ST_F_CLR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            mobt_pkg::ST_F_CLR:
            begin
                ctrl.op    = mobt_pkg::LOP_CLEAR;
                k_next     = '0;
                state_next = mobt_pkg::ST_F_RD;
            end
            mobt_pkg::ST_F_RD:
            begin
                ctrl.op    = mobt_pkg::LOP_READ;
                state_next = mobt_pkg::ST_F_MAC;
            end
            mobt_pkg::ST_F_MAC:
            begin
                ctrl.op = mobt_pkg::LOP_MAC;
                if (k_end_srcs) begin
                    state_next = mobt_pkg::ST_F_NET;
                end
                else begin
                    k_next     = k_reg + 1'b1;
                    state_next = mobt_pkg::ST_F_RD;
                end
            end
            mobt_pkg::ST_F_NET:
            begin
                ctrl.op    = mobt_pkg::LOP_NET;
                k_next     = '0;
                state_next = mobt_pkg::ST_S_IDX;
            end
            mobt_pkg::ST_S_IDX:
            begin
                state_next = mobt_pkg::ST_S_Y;
            end
            mobt_pkg::ST_S_Y:
            begin
                ctrl.op = mobt_pkg::LOP_PRIME;
                if (k_end_nodes) begin
                    k_next = '0;
                    if (layer_reg == last_layer) begin
                        state_next = mobt_pkg::ST_B_OUT;
                    end
                    else begin
                        layer_next = layer_reg + 1'b1;
                        state_next = mobt_pkg::ST_F_CLR;
                    end
                end
                else begin
                    k_next     = k_reg + 1'b1;
                    state_next = mobt_pkg::ST_S_IDX;
                end
            end
            mobt_pkg::ST_B_OUT:
            begin
                state_next = mobt_pkg::ST_B_GOUT;
            end
            mobt_pkg::ST_B_GOUT:
            begin
                ctrl.op  = mobt_pkg::LOP_GRAD;
                ctrl.sel = '0;
                k_next   = '0;
                if (layer_reg == '0) begin
                    state_next = mobt_pkg::ST_U_STEP;
                end
                else begin
                    state_next = mobt_pkg::ST_B_RD;
                end
            end
            mobt_pkg::ST_B_RD:
            begin
                ctrl.op    = mobt_pkg::LOP_READ;
                state_next = mobt_pkg::ST_B_PROD;
            end
            mobt_pkg::ST_B_PROD:
            begin
                ctrl.op    = mobt_pkg::LOP_BPROD;
                state_next = mobt_pkg::ST_B_SUM1;
            end
            mobt_pkg::ST_B_SUM1:
            begin
                state_next = mobt_pkg::ST_B_SUM2;
            end
            mobt_pkg::ST_B_SUM2:
            begin
                state_next = mobt_pkg::ST_B_GRAD;
            end
            mobt_pkg::ST_B_GRAD:
            begin
                ctrl.op    = mobt_pkg::LOP_GRAD;
                ctrl.layer = layer_reg - 1'b1;
                ctrl.value = lower_delta;
                if (k_end_srcs) begin
                    k_next     = '0;
                    layer_next = layer_reg - 1'b1;
                    if (layer_reg == LW'(1)) begin
                        state_next = mobt_pkg::ST_U_STEP;
                    end
                    else begin
                        state_next = mobt_pkg::ST_B_RD;
                    end
                end
                else begin
                    k_next     = k_reg + 1'b1;
                    state_next = mobt_pkg::ST_B_RD;
                end
            end
            mobt_pkg::ST_U_STEP:
            begin
                ctrl.op    = mobt_pkg::LOP_STEP;
                k_next     = '0;
                state_next = mobt_pkg::ST_U_RD;
            end
            mobt_pkg::ST_U_RD:
            begin
                ctrl.op    = mobt_pkg::LOP_READ;
                state_next = mobt_pkg::ST_U_MUL;
            end
            mobt_pkg::ST_U_MUL:
            begin
                ctrl.op    = mobt_pkg::LOP_UMUL;
                state_next = mobt_pkg::ST_U_WR;
            end
            mobt_pkg::ST_U_WR:
            begin
                ctrl.op = mobt_pkg::LOP_WRITE;
                if (k_end_srcs) begin
                    state_next = mobt_pkg::ST_U_BIAS;
                end
                else begin
                    k_next     = k_reg + 1'b1;
                    state_next = mobt_pkg::ST_U_RD;
                end
            end
            mobt_pkg::ST_U_BIAS:
            begin
                ctrl.op = mobt_pkg::LOP_BIAS;
                k_next  = '0;
                if (layer_reg == last_layer) begin
                    state_next = mobt_pkg::ST_E_OUT;
                end
                else begin
                    layer_next = layer_reg + 1'b1;
                    state_next = mobt_pkg::ST_U_STEP;
                end
            end
            mobt_pkg::ST_E_OUT:
            begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    err_acc_next  = epoch_end_reg ? '0 : err_sat;
                    state_next    = mobt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mobt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg         <= mobt_pkg::ST_IDLE;
            layer_reg         <= '0;
            k_reg             <= '0;
            m_tvalid_reg      <= 1'b0;
            err_acc_reg       <= '0;
            layer_count_reg   <= 3'd2;
            hidden_nodes_reg  <= 4'd2;
            learning_rate_reg <= 13'd410;
            error_limit_reg   <= 13'd41;
        end
        else begin
            state_reg    <= state_next;
            layer_reg    <= layer_next;
            k_reg        <= k_next;
            m_tvalid_reg <= m_tvalid_next;
            err_acc_reg  <= err_acc_next;
            if (wr_en) begin
                case (wr_index)
                    mobt_pkg::REG_LAYER_COUNT:   layer_count_reg   <= wr_data[2:0];
                    mobt_pkg::REG_HIDDEN_NODES:  hidden_nodes_reg  <= wr_data[3:0];
                    mobt_pkg::REG_LEARNING_RATE: learning_rate_reg <= wr_data;
                    mobt_pkg::REG_ERROR_LIMIT:   error_limit_reg   <= wr_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == mobt_pkg::ST_IDLE && accept && s_tuser == mobt_pkg::ACT_TRAIN) begin
            inp_reg[0][0] <= mobt_pkg::X_W'($signed(s_tdata[15:0]));
            if (mobt_pkg::IN_CNT > 1) begin
                inp_reg[0][1] <= mobt_pkg::X_W'($signed(s_tdata[31:16]));
            end
            target_reg    <= s_tdata[44:32];
            epoch_end_reg <= s_tlast;
        end
        if (state_reg == mobt_pkg::ST_S_Y) begin
            if (layer_reg == last_layer) begin
                yout_reg <= y_sig;
            end
            else begin
                inp_reg[layer_reg + 1'b1][k_reg] <= $signed({4'b0, y_sig});
            end
        end
        if (state_reg == mobt_pkg::ST_B_OUT) begin
            delta_reg <= mobt_pkg::sat_wgt(64'(-err_diff));
        end
        if (state_reg == mobt_pkg::ST_E_OUT && out_free) begin
            out_y_reg     <= yout_reg;
            out_valid_reg <= epoch_end_reg;
            out_err_reg   <= epoch_end_reg ? err_sat : '0;
            out_conv_reg  <= epoch_end_reg && (err_sat < mobt_pkg::ERR_W'(error_limit_reg));
        end
    end

    for (genvar i = 0; i < mobt_pkg::MAX_NODES; i++) begin : g_lane
        mobt_lane u_lane (
            .clk     (clk),
            .lane_id (NW'(i)),
            .ctrl    (ctrl),
            .net     (lane_net[i]),
            .bprod   (lane_bprod[i])
        );
    end

    mobt_merge u_merge (
        .clk   (clk),
        .bprod (lane_bprod),
        .total (total)
    );

    mobt_sigmoid u_sigmoid (
        .clk (clk),
        .net (lane_net[k_reg]),
        .y   (y_sig)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_conv_reg, out_err_reg, out_y_reg};
    assign m_tuser  = out_valid_reg;

endmodule

// ----- rtl/mobt_lane.sv -----
// One node lane: weight and bias storage, multiply-accumulate, gradient and update.
module mobt_lane (
    input  logic                         clk,
    input  logic [mobt_pkg::NODE_W-1:0]  lane_id,
    input  mobt_pkg::lane_ctrl_t         ctrl,
    output mobt_pkg::net_t               net,
    output mobt_pkg::bprod_t             bprod
);

    logic signed [mobt_pkg::WGT_W-1:0]   wmem [2**mobt_pkg::LANE_AW];
    logic signed [mobt_pkg::WGT_W-1:0]   rdata_reg;
    logic signed [mobt_pkg::WGT_W-1:0]   bias_reg [mobt_pkg::MAX_LAYERS];
    logic [mobt_pkg::Y_W-1:0]            prime_reg [mobt_pkg::MAX_LAYERS];
    logic signed [mobt_pkg::G_W-1:0]     g_reg [mobt_pkg::MAX_LAYERS];
    logic signed [mobt_pkg::ACC_W-1:0]   acc_reg;
    logic signed [mobt_pkg::NET_W-1:0]   net_reg;
    logic signed [mobt_pkg::STEP_W-1:0]  step_reg;
    logic signed [mobt_pkg::BPROD_W-1:0] bprod_reg;
    logic signed [mobt_pkg::UPROD_W-1:0] uprod_reg;
    logic signed [mobt_pkg::WGT_W-1:0]   whold_reg;

    logic [mobt_pkg::LANE_AW-1:0]        addr;
    logic                                active;
    logic                                picked;
    logic signed [mobt_pkg::ACC_W-1:0]   mac_prod;
    logic signed [mobt_pkg::NET_W-1:0]   net_next;
    logic [2*mobt_pkg::Y_W-1:0]          prime_full;
    logic signed [mobt_pkg::WGT_W+mobt_pkg::Y_W:0] g_full;
    logic signed [mobt_pkg::RATE_W+mobt_pkg::G_W:0] s_full;
    logic signed [mobt_pkg::BPROD_W-1:0] bp;
    logic signed [mobt_pkg::UPROD_W-1:0] up;
    logic signed [mobt_pkg::WGT_W-1:0]   w_new;
    logic signed [mobt_pkg::WGT_W-1:0]   b_new;
    logic [mobt_pkg::Y_W-1:0]            one_minus_y;

    assign addr   = {ctrl.layer, ctrl.src};
    assign active = {1'b0, lane_id} < ctrl.nodes;
    assign picked = ctrl.sel == lane_id;

    always_comb
    begin
        one_minus_y = mobt_pkg::Y_W'(mobt_pkg::ONE) - ctrl.y;
        mac_prod    = rdata_reg * ctrl.x;
        net_next    = mobt_pkg::NET_W'(bias_reg[ctrl.layer])
                    + mobt_pkg::NET_W'(acc_reg >>> mobt_pkg::FRAC_BITS);
        prime_full  = ctrl.y * one_minus_y;
        g_full      = ctrl.value * $signed({1'b0, prime_reg[ctrl.layer]});
        s_full      = $signed({1'b0, ctrl.rate}) * g_reg[ctrl.layer];
        bp          = rdata_reg * g_reg[ctrl.layer];
        up          = step_reg * ctrl.x;
        w_new       = mobt_pkg::sat_wgt(64'(whold_reg) - 64'(uprod_reg >>> mobt_pkg::FRAC_BITS));
        b_new       = mobt_pkg::sat_wgt(64'(bias_reg[ctrl.layer]) - 64'(step_reg));
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.op == mobt_pkg::LOP_WLOAD && picked) begin
            wmem[addr] <= ctrl.value;
        end
        else if (ctrl.op == mobt_pkg::LOP_WRITE && active) begin
            wmem[addr] <= w_new;
        end
        if (ctrl.op == mobt_pkg::LOP_READ) begin
            rdata_reg <= wmem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            mobt_pkg::LOP_BLOAD:
            begin
                if (picked) begin
                    bias_reg[ctrl.layer] <= ctrl.value;
                end
            end
            mobt_pkg::LOP_CLEAR:
            begin
                acc_reg <= '0;
            end
            mobt_pkg::LOP_MAC:
            begin
                acc_reg <= acc_reg + mac_prod;
            end
            mobt_pkg::LOP_NET:
            begin
                net_reg <= net_next;
            end
            mobt_pkg::LOP_PRIME:
            begin
                if (picked) begin
                    prime_reg[ctrl.layer] <= mobt_pkg::Y_W'(prime_full >> mobt_pkg::FRAC_BITS);
                end
            end
            mobt_pkg::LOP_GRAD:
            begin
                if (picked) begin
                    g_reg[ctrl.layer] <= mobt_pkg::G_W'(g_full >>> mobt_pkg::FRAC_BITS);
                end
            end
            mobt_pkg::LOP_BPROD:
            begin
                bprod_reg <= active ? bp : '0;
            end
            mobt_pkg::LOP_STEP:
            begin
                step_reg <= mobt_pkg::STEP_W'(s_full >>> mobt_pkg::FRAC_BITS);
            end
            mobt_pkg::LOP_UMUL:
            begin
                uprod_reg <= up;
                whold_reg <= rdata_reg;
            end
            mobt_pkg::LOP_BIAS:
            begin
                if (active) begin
                    bias_reg[ctrl.layer] <= b_new;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign net   = net_reg;
    assign bprod = bprod_reg;

endmodule

// ----- rtl/mobt_merge.sv -----
// Two-stage registered adder tree that sums the lane products.
module mobt_merge (
    input  logic                               clk,
    input  mobt_pkg::bprod_t                   bprod [mobt_pkg::MAX_NODES],
    output logic signed [mobt_pkg::SUM_W-1:0]  total
);

    localparam int HALF = (mobt_pkg::MAX_NODES + 1) / 2;

    logic signed [mobt_pkg::SUM_W-1:0] pair_reg [HALF];
    logic signed [mobt_pkg::SUM_W-1:0] pair_next [HALF];
    logic signed [mobt_pkg::SUM_W-1:0] total_reg;
    logic signed [mobt_pkg::SUM_W-1:0] total_next;

    always_comb
    begin
        for (int i = 0; i < HALF; i++) begin
            pair_next[i] = mobt_pkg::SUM_W'(bprod[2*i]);
            if (2*i + 1 < mobt_pkg::MAX_NODES) begin
                pair_next[i] = pair_next[i] + mobt_pkg::SUM_W'(bprod[2*i+1]);
            end
        end
        total_next = '0;
        for (int i = 0; i < HALF; i++) begin
            total_next = total_next + pair_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        pair_reg  <= pair_next;
        total_reg <= total_next;
    end

    assign total = total_reg;

endmodule

// ----- rtl/mobt_sigmoid.sv -----
// Sigmoid lookup: clamps the net input to the table range and reads the table.
module mobt_sigmoid (
    input  logic                        clk,
    input  mobt_pkg::net_t              net,
    output logic [mobt_pkg::Y_W-1:0]    y
);

    localparam mobt_pkg::sig_rom_t SIG_ROM = mobt_pkg::build_sig_rom();
    localparam int SIG_SHIFT = $clog2(mobt_pkg::SIG_STEP);

    logic signed [mobt_pkg::NET_W:0]  offset;
    logic signed [mobt_pkg::NET_W:0]  scaled;
    logic [mobt_pkg::SIG_IW-1:0]      idx;
    logic [mobt_pkg::Y_W-1:0]         y_reg;

    always_comb
    begin
        offset = (mobt_pkg::NET_W+1)'(net) + (mobt_pkg::NET_W+1)'(8 * mobt_pkg::ONE);
        scaled = offset >>> SIG_SHIFT;
        if (offset < 0) begin
            idx = '0;
        end
        else if (scaled > (mobt_pkg::NET_W+1)'(mobt_pkg::SIG_DEPTH - 1)) begin
            idx = mobt_pkg::SIG_IW'(mobt_pkg::SIG_DEPTH - 1);
        end
        else begin
            idx = scaled[mobt_pkg::SIG_IW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg <= SIG_ROM[idx];
    end

    assign y = y_reg;

endmodule

// ----- tb/mlp_online_backprop_trainer_top_tb.sv -----
// Self-checking testbench for the online backpropagation perceptron trainer top level.
module mlp_online_backprop_trainer_top_tb;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]         act;
        logic signed [15:0] fa;
        logic signed [15:0] fb;
        logic [12:0]        tgt;
        logic               eend;
        logic [1:0]         lsel;
        logic [2:0]         nsel;
        logic [2:0]         ssel;
        logic signed [23:0] lv;
    } sample_t;

    typedef struct packed {
        logic [12:0] y;
        logic [23:0] err;
        logic        ev;
        logic        conv;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        wr_en = 1'b0;
    logic [1:0]  wr_index = '0;
    logic [12:0] wr_data = '0;

    sample_t  pending_samples[$];
    sample_t  cur_sample;
    outcome_t expected_outcomes[$];
    int       error_count = 0;
    int       outcome_count = 0;
    int       gap_left = 0;
    int       burst_left = 4;
    int       hold_left = 0;
    bit       hold_done = 1'b0;
    int       stall_mode = 0;
    longint   cycle_count = 0;

    // Predictor state.
    logic [2:0]  p_layers;
    logic [3:0]  p_hidden;
    logic [12:0] p_rate;
    logic [12:0] p_limit;
    longint      p_wgt[256];
    longint      p_bias[32];
    longint      p_err_sum;
    longint      sig_lut[1024];

    mlp_online_backprop_trainer_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void fill_sigmoid_lut();
        longint z, a, n, f, term, sum, e, d, p;
        for (int i = 0; i < 1024; i++)
        begin
            z = -8 * 4096 + longint'(i) * 64;
            a = (z < 0) ? -z : z;
            n = a >> 12;
            f = a & 4095;
            term = longint'(1) << 30;
            sum = term;
            for (int k = 1; k <= 16; k++)
            begin
                term = (term * f) / (longint'(k) * 4096);
                sum = (k % 2 == 1) ? sum - term : sum + term;
            end
            e = sum;
            for (longint r = 0; r < n; r++)
                e = (e * 395007542) >> 30;
            d = (longint'(1) << 30) + e;
            p = ((longint'(4096) << 30) + d / 2) / d;
            sig_lut[i] = (z >= 0) ? p : 4096 - p;
        end
    endfunction

    function automatic longint clip24(longint v);
        if (v > 8388607)
            return 8388607;
        if (v < -8388608)
            return -8388608;
        return v;
    endfunction

    function automatic longint sigmoid_of(longint net);
        longint idx;
        idx = (net < -8 * 4096) ? longint'(0) : (net + 8 * 4096) / 64;
        if (idx > 1023)
            idx = 1023;
        return sig_lut[idx];
    endfunction

    function automatic void train_and_predict(sample_t s);
        int       nl, nh;
        int       nodes[4];
        int       srcs[4];
        longint   x[4][8];
        longint   pr[4][8];
        longint   dl[4][8];
        longint   acc, net, y, yout, g, st, diff;
        outcome_t o;
        nl = (int'(p_layers) < 1) ? 1 : ((int'(p_layers) > 4) ? 4 : int'(p_layers));
        nh = (int'(p_hidden) < 1) ? 1 : ((int'(p_hidden) > 8) ? 8 : int'(p_hidden));
        for (int l = 0; l < 4; l++)
            for (int j = 0; j < 8; j++)
            begin
                x[l][j] = 0;
                pr[l][j] = 0;
                dl[l][j] = 0;
            end
        x[0][0] = longint'(s.fa);
        x[0][1] = longint'(s.fb);
        yout = 0;
        for (int l = 0; l < nl; l++)
        begin
            nodes[l] = (l == nl - 1) ? 1 : nh;
            srcs[l] = (l == 0) ? 2 : nh;
            for (int j = 0; j < nodes[l]; j++)
            begin
                acc = 0;
                for (int k = 0; k < srcs[l]; k++)
                    acc += p_wgt[(l * 8 + j) * 8 + k] * x[l][k];
                net = p_bias[l * 8 + j] + (acc >>> 12);
                y = sigmoid_of(net);
                pr[l][j] = (y * (4096 - y)) >>> 12;
                if (l + 1 < nl)
                    x[l + 1][j] = y;
                yout = y;
            end
        end
        dl[nl - 1][0] = clip24(yout - longint'(s.tgt));
        for (int l = nl - 1; l >= 1; l--)
            for (int k = 0; k < srcs[l]; k++)
            begin
                acc = 0;
                for (int j = 0; j < nodes[l]; j++)
                begin
                    g = (dl[l][j] * pr[l][j]) >>> 12;
                    acc += p_wgt[(l * 8 + j) * 8 + k] * g;
                end
                dl[l - 1][k] = clip24(acc >>> 12);
            end
        for (int l = 0; l < nl; l++)
            for (int j = 0; j < nodes[l]; j++)
            begin
                g = (dl[l][j] * pr[l][j]) >>> 12;
                st = (longint'(p_rate) * g) >>> 12;
                for (int k = 0; k < srcs[l]; k++)
                    p_wgt[(l * 8 + j) * 8 + k] =
                        clip24(p_wgt[(l * 8 + j) * 8 + k] - ((st * x[l][k]) >>> 12));
                p_bias[l * 8 + j] = clip24(p_bias[l * 8 + j] - st);
            end
        diff = longint'(s.tgt) - yout;
        p_err_sum += (diff * diff) >>> 12;
        if (p_err_sum > 16777215)
            p_err_sum = 16777215;
        o.y = 13'(yout);
        if (s.eend)
        begin
            o.err = 24'(p_err_sum);
            o.ev = 1'b1;
            o.conv = (p_err_sum < longint'(p_limit));
            p_err_sum = 0;
        end
        else
        begin
            o.err = '0;
            o.ev = 1'b0;
            o.conv = 1'b0;
        end
        expected_outcomes = {expected_outcomes, o};
    endfunction

    function automatic void apply_sample(sample_t s);
        if (s.act == mobt_pkg::ACT_LOAD_W)
            p_wgt[(s.lsel * 8 + s.nsel) * 8 + s.ssel] = longint'(s.lv);
        else if (s.act == mobt_pkg::ACT_LOAD_B)
            p_bias[s.lsel * 8 + s.nsel] = longint'(s.lv);
        else if (s.act == mobt_pkg::ACT_TRAIN)
            train_and_predict(s);
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk)
    begin
        if (rst_n && (!s_tvalid || s_tready))
        begin
            if (s_tvalid)
                apply_sample(cur_sample);
            if (gap_left > 0 || pending_samples.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else
            begin
                cur_sample = pending_samples.pop_front();
                s_tdata <= {3'b0, cur_sample.lv, cur_sample.ssel, cur_sample.nsel,
                            cur_sample.lsel, cur_sample.tgt, cur_sample.fb, cur_sample.fa};
                s_tuser <= cur_sample.act;
                s_tlast <= cur_sample.eend;
                s_tvalid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 600);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Long receiver hold-off once, so the block fills and stalls its input.
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && outcome_count == 40)
        begin
            hold_left <= 3000;
            hold_done <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (cycle_count % 500 == 0)
            stall_mode <= $urandom_range(0, 2);
        if (hold_left > 0)
            m_tready <= 1'b0;
        else if (stall_mode == 0)
            m_tready <= 1'b1;
        else if (stall_mode == 1)
            m_tready <= 1'($urandom_range(0, 1));
        else
            m_tready <= ($urandom_range(0, 7) == 0);
    end

    // Checker.
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            outcome_count <= outcome_count + 1;
            if (expected_outcomes.size() == 0)
            begin
                report("result count", 1, 0);
            end
            else
            begin
                want = expected_outcomes.pop_front();
                if (m_tdata[12:0] !== want.y)
                    report("network_output", m_tdata[12:0], want.y);
                if (m_tdata[36:13] !== want.err)
                    report("epoch_error", m_tdata[36:13], want.err);
                if (m_tdata[37] !== want.conv)
                    report("converged", m_tdata[37], want.conv);
                if (m_tuser !== want.ev)
                    report("error_valid", m_tuser, want.ev);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 4000000)
        begin
            $display("mlp_online_backprop_trainer_top_tb failed");
            $finish;
        end
    end

    task automatic push_load(input logic [1:0] act, input int l, input int n, input int k,
                             input longint v);
        sample_t s;
        s = '0;
        s.act = act;
        s.lsel = 2'(l);
        s.nsel = 3'(n);
        s.ssel = 3'(k);
        s.lv = 24'(v);
        s.fa = 16'($urandom);
        s.fb = 16'($urandom);
        s.tgt = 13'($urandom);
        pending_samples = {pending_samples, s};
    endtask

    task automatic push_train(input longint fa, input longint fb, input int tgt, input bit ee);
        sample_t s;
        s = '0;
        s.act = mobt_pkg::ACT_TRAIN;
        s.fa = 16'(fa);
        s.fb = 16'(fb);
        s.tgt = 13'(tgt);
        s.eend = ee;
        s.lsel = 2'($urandom);
        s.nsel = 3'($urandom);
        s.ssel = 3'($urandom);
        s.lv = 24'($urandom);
        pending_samples = {pending_samples, s};
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_samples.size() != 0 || s_tvalid || expected_outcomes.size() != 0);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_reg(input mobt_pkg::reg_index_t idx, input logic [12:0] v);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= v;
        @(posedge clk);
        wr_en <= 1'b0;
        if (idx == mobt_pkg::REG_LAYER_COUNT)
            p_layers = v[2:0];
        else if (idx == mobt_pkg::REG_HIDDEN_NODES)
            p_hidden = v[3:0];
        else if (idx == mobt_pkg::REG_LEARNING_RATE)
            p_rate = v;
        else
            p_limit = v;
        @(posedge clk);
    endtask

    task automatic random_trains(input int count);
        int t;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                push_load(2'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                          $signed($urandom_range(0, 32767)) - 16384);
            else if ($urandom_range(0, 29) == 0)
                push_load(ACT_UNUSED, $urandom, $urandom, $urandom, $urandom);
            else
            begin
                t = ($urandom_range(0, 15) == 0) ? $urandom_range(4097, 8191)
                                                 : $urandom_range(0, 4096);
                if ($urandom_range(0, 3) == 0)
                    push_train($signed(16'($urandom)), $signed(16'($urandom)), t,
                               $urandom_range(0, 5) == 0);
                else
                    push_train($signed($urandom_range(0, 16383)) - 8192,
                               $signed($urandom_range(0, 16383)) - 8192, t,
                               $urandom_range(0, 5) == 0);
            end
        end
        push_train(4096, 0, 4096, 1'b1);
    endtask

    initial
    begin
        fill_sigmoid_lut();
        p_layers = 2;
        p_hidden = 2;
        p_rate = 410;
        p_limit = 41;
        p_err_sum = 0;
        for (int i = 0; i < 256; i++)
            p_wgt[i] = 0;
        for (int i = 0; i < 32; i++)
            p_bias[i] = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int l = 0; l < 4; l++)
            for (int n = 0; n < 8; n++)
            begin
                for (int k = 0; k < 8; k++)
                    push_load(mobt_pkg::ACT_LOAD_W, l, n, k,
                              $signed($urandom_range(0, 16383)) - 8192);
                push_load(mobt_pkg::ACT_LOAD_B, l, n, 0, $signed($urandom_range(0, 8191)) - 4096);
            end

        push_train(0, 0, 0, 1'b0);
        push_train(32767, -32768, 4096, 1'b0);
        push_train(-32768, 32767, 0, 1'b1);
        push_train(4096, 4096, 8191, 1'b1);
        push_load(ACT_UNUSED, 3, 7, 7, 8388607);
        push_load(mobt_pkg::ACT_LOAD_W, 0, 0, 0, 8388607);
        push_load(mobt_pkg::ACT_LOAD_B, 0, 0, 0, -8388608);
        push_train(32767, 32767, 2048, 1'b0);
        push_load(mobt_pkg::ACT_LOAD_W, 0, 0, 1, -8388608);
        push_load(mobt_pkg::ACT_LOAD_B, 1, 0, 0, 8388607);
        push_train(-32768, -32768, 4096, 1'b1);
        push_load(mobt_pkg::ACT_LOAD_W, 0, 0, 0, 1000);
        push_load(mobt_pkg::ACT_LOAD_W, 0, 0, 1, -1000);
        push_load(mobt_pkg::ACT_LOAD_B, 0, 0, 0, 0);
        push_load(mobt_pkg::ACT_LOAD_B, 1, 0, 0, 0);
        push_train(2048, -2048, 1024, 1'b1);
        random_trains(60);
        wait_drained();

        write_reg(mobt_pkg::REG_LAYER_COUNT, 1);
        write_reg(mobt_pkg::REG_HIDDEN_NODES, 1);
        write_reg(mobt_pkg::REG_LEARNING_RATE, 4096);
        write_reg(mobt_pkg::REG_ERROR_LIMIT, 4096);
        random_trains(80);
        wait_drained();

        write_reg(mobt_pkg::REG_LAYER_COUNT, 4);
        write_reg(mobt_pkg::REG_HIDDEN_NODES, 8);
        write_reg(mobt_pkg::REG_LEARNING_RATE, 0);
        write_reg(mobt_pkg::REG_ERROR_LIMIT, 0);
        random_trains(100);
        wait_drained();

        write_reg(mobt_pkg::REG_LAYER_COUNT, 7);
        write_reg(mobt_pkg::REG_HIDDEN_NODES, 15);
        write_reg(mobt_pkg::REG_LEARNING_RATE, 8191);
        write_reg(mobt_pkg::REG_ERROR_LIMIT, 8191);
        random_trains(60);
        wait_drained();

        write_reg(mobt_pkg::REG_LAYER_COUNT, 0);
        write_reg(mobt_pkg::REG_HIDDEN_NODES, 0);
        write_reg(mobt_pkg::REG_LEARNING_RATE, 205);
        write_reg(mobt_pkg::REG_ERROR_LIMIT, 41);
        random_trains(60);
        wait_drained();

        write_reg(mobt_pkg::REG_LAYER_COUNT, 3);
        write_reg(mobt_pkg::REG_HIDDEN_NODES, 5);
        write_reg(mobt_pkg::REG_LEARNING_RATE, 410);
        write_reg(mobt_pkg::REG_ERROR_LIMIT, 2000);
        random_trains(80);
        wait_drained();

        if (error_count == 0)
            $display("mlp_online_backprop_trainer_top_tb passed");
        else
            $display("mlp_online_backprop_trainer_top_tb failed");
        $finish;
    end

endmodule
